// ===== rtl/core/sfpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpwm_pkg
// Shared types and constants for the sync-framed PWM and LED command parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfpwm_pkg;

  localparam logic [7:0]  SyncFirst    = 8'h55;
  localparam logic [7:0]  SyncSecond   = 8'hAA;
  localparam logic [15:0] DutyOneReset = 16'd2000;
  localparam logic [15:0] DutyTwoReset = 16'd1000;
  localparam int          LedCount     = 3;

  localparam logic [2:0] LeftHunt    = 3'd0;
  localparam logic [2:0] LeftMode    = 3'd1;
  localparam logic [2:0] LeftTwoLow  = 3'd2;
  localparam logic [2:0] LeftTwoHigh = 3'd3;
  localparam logic [2:0] LeftOneLow  = 3'd4;
  localparam logic [2:0] LeftOneHigh = 3'd5;

  localparam logic [1:0] LedOff    = 2'd0;
  localparam logic [1:0] LedOn     = 2'd1;
  localparam logic [1:0] LedToggle = 2'd2;
  localparam logic [1:0] LedHold   = 2'd3;

  localparam logic KindByte = 1'b0;
  localparam logic KindTick = 1'b1;

  typedef struct packed {
    logic                saw_sync_first;
    logic [2:0]          bytes_left;
    logic [15:0]         staged_duty_one;
    logic [15:0]         staged_duty_two;
    logic [15:0]         active_duty_one;
    logic [15:0]         active_duty_two;
    logic [5:0]          led_modes;
    logic [LedCount-1:0] led_levels;
  } parser_state_t;

endpackage

// ===== rtl/core/sfpwm_frame_logic.sv =====
// ----------------------------------------------------------------------------
// sfpwm_frame_logic
// Next-state logic for one word: sync hunt, frame byte capture, LED tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfpwm_frame_logic (
  input  sfpwm_pkg::parser_state_t state_cur,
  input  logic                     kind,
  input  logic [7:0]               rx_byte,
  output sfpwm_pkg::parser_state_t state_nxt,
  output logic                     applied
);
  import sfpwm_pkg::*;

  always_comb begin
    logic [1:0] mode;
    state_nxt = state_cur;
    applied   = 1'b0;
    mode      = LedOff;
    if (kind == KindTick) begin
      for (int n = 0; n < LedCount; n++) begin
        mode = state_cur.led_modes[4 - 2*n +: 2];
        case (mode)
          LedOff:    state_nxt.led_levels[n] = 1'b0;
          LedOn:     state_nxt.led_levels[n] = 1'b1;
          LedToggle: state_nxt.led_levels[n] = ~state_cur.led_levels[n];
          default:   state_nxt.led_levels[n] = state_cur.led_levels[n];
        endcase
      end
    end else if (state_cur.bytes_left == LeftHunt) begin
      if (state_cur.saw_sync_first && rx_byte == SyncSecond) begin
        state_nxt.saw_sync_first = 1'b0;
        state_nxt.bytes_left     = LeftOneHigh;
      end else begin
        state_nxt.saw_sync_first = (rx_byte == SyncFirst);
      end
    end else begin
      unique case (state_cur.bytes_left)
        LeftOneHigh: state_nxt.staged_duty_one = {rx_byte, 8'h00};
        LeftOneLow:  state_nxt.staged_duty_one = {state_cur.staged_duty_one[15:8], rx_byte};
        LeftTwoHigh: state_nxt.staged_duty_two = {rx_byte, 8'h00};
        LeftTwoLow:  state_nxt.staged_duty_two = {state_cur.staged_duty_two[15:8], rx_byte};
        LeftMode: begin
          state_nxt.led_modes       = rx_byte[7:2];
          state_nxt.active_duty_one = state_cur.staged_duty_one;
          state_nxt.active_duty_two = state_cur.staged_duty_two;
          applied                   = 1'b1;
        end
        default: ;
      endcase
      state_nxt.bytes_left = state_cur.bytes_left - 3'd1;
    end
  end

endmodule

// ===== rtl/core/sync_framed_pwm_led_command_parser.sv =====
// ----------------------------------------------------------------------------
// sync_framed_pwm_led_command_parser
// Hunts for the 0x55 0xAA sync pair, captures two PWM duties and LED modes,
// and steps the LED pins on blink ticks.
// ----------------------------------------------------------------------------
//   channel  | ports                                         | direction
//   ---------+-----------------------------------------------+----------
//   input    | in_valid, in_stall, in_kind, in_rx_byte        | in
//   result   | out_valid, out_stall, out_pwm1_compare,        | out
//            | out_pwm2_compare, out_led_outputs,             |
//            | out_frame_applied                              |
//
// One word per cycle sustained while the result is not stalled; each word is
// held in the input register and then loaded into the result register.
// Synchronous active-low reset clears both stage valids and the parser state.
// A stalled result holds; the input register still takes one more word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_framed_pwm_led_command_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pwm1_compare,
  output logic [15:0] out_pwm2_compare,
  output logic [2:0]  out_led_outputs,
  output logic        out_frame_applied
);
  import sfpwm_pkg::*;

  logic          in_valid_r;
  logic          kind_r;
  logic [7:0]    rx_byte_r;
  parser_state_t state_r;
  parser_state_t state_nxt;
  logic          applied_nxt;
  logic          out_valid_r;
  logic [15:0]   pwm1_r;
  logic [15:0]   pwm2_r;
  logic [2:0]    led_r;
  logic          applied_r;
  logic          out_load;
  logic          in_take;

  assign out_load = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  sfpwm_frame_logic u_frame (
    .state_cur (state_r),
    .kind      (kind_r),
    .rx_byte   (rx_byte_r),
    .state_nxt (state_nxt),
    .applied   (applied_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (out_load) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r    <= in_kind;
      rx_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.saw_sync_first  <= 1'b0;
      state_r.bytes_left      <= LeftHunt;
      state_r.staged_duty_one <= 16'd0;
      state_r.staged_duty_two <= 16'd0;
      state_r.active_duty_one <= DutyOneReset;
      state_r.active_duty_two <= DutyTwoReset;
      state_r.led_modes       <= 6'd0;
      state_r.led_levels      <= 3'd0;
    end else if (out_load) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pwm1_r    <= state_nxt.active_duty_one;
      pwm2_r    <= state_nxt.active_duty_two;
      led_r     <= state_nxt.led_levels;
      applied_r <= applied_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pwm1_compare  = pwm1_r;
  assign out_pwm2_compare  = pwm2_r;
  assign out_led_outputs   = led_r;
  assign out_frame_applied = applied_r;

endmodule

// ===== verif/sfpwm_checker.sv =====
// ----------------------------------------------------------------------------
// sfpwm_checker
// Watches both channels of the sync-framed PWM and LED command parser. It
// keeps a shadow copy of the parser state and predicts the result word of
// every accepted input word. Each accepted result word is compared with the
// oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfpwm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_pwm1_compare,
  input  logic [15:0] out_pwm2_compare,
  input  logic [2:0]  out_led_outputs,
  input  logic        out_frame_applied,
  output int          mismatch_count,
  output int          pending_count,
  output int          checked_count,
  output int          frame_count
);
  import sfpwm_pkg::*;

  typedef struct packed {
    logic [15:0] pwm1;
    logic [15:0] pwm2;
    logic [2:0]  leds;
    logic        applied;
  } parser_word_t;

  parser_state_t shadow;
  parser_word_t  pending_results[$];

  function automatic parser_word_t predict_parse(input logic kind, input logic [7:0] data);
    parser_word_t w;
    logic [1:0]   mode;
    w.applied = 1'b0;
    if (kind == KindTick) begin
      for (int n = 0; n < LedCount; n++) begin
        mode = shadow.led_modes[4 - 2 * n +: 2];
        case (mode)
          LedOff:    shadow.led_levels[n] = 1'b0;
          LedOn:     shadow.led_levels[n] = 1'b1;
          LedToggle: shadow.led_levels[n] = ~shadow.led_levels[n];
          default:   ;
        endcase
      end
    end else if (shadow.bytes_left == LeftHunt) begin
      if (shadow.saw_sync_first && data == SyncSecond) begin
        shadow.saw_sync_first = 1'b0;
        shadow.bytes_left     = LeftOneHigh;
      end else begin
        shadow.saw_sync_first = (data == SyncFirst);
      end
    end else begin
      case (shadow.bytes_left)
        LeftOneHigh: shadow.staged_duty_one = {data, 8'h00};
        LeftOneLow:  shadow.staged_duty_one = shadow.staged_duty_one | {8'h00, data};
        LeftTwoHigh: shadow.staged_duty_two = {data, 8'h00};
        LeftTwoLow:  shadow.staged_duty_two = shadow.staged_duty_two | {8'h00, data};
        LeftMode: begin
          shadow.led_modes       = data[7:2];
          shadow.active_duty_one = shadow.staged_duty_one;
          shadow.active_duty_two = shadow.staged_duty_two;
          w.applied              = 1'b1;
        end
        default: ;
      endcase
      shadow.bytes_left = shadow.bytes_left - 3'd1;
    end
    w.pwm1 = shadow.active_duty_one;
    w.pwm2 = shadow.active_duty_two;
    w.leds = shadow.led_levels;
    return w;
  endfunction

  always @(posedge clk) begin
    parser_word_t got;
    parser_word_t want;
    if (!rst_n) begin
      shadow = '{saw_sync_first: 1'b0, bytes_left: LeftHunt, staged_duty_one: 16'h0000,
                 staged_duty_two: 16'h0000, active_duty_one: DutyOneReset,
                 active_duty_two: DutyTwoReset, led_modes: 6'h00, led_levels: 3'h0};
      pending_results.delete();
      mismatch_count = 0;
      checked_count  = 0;
      frame_count    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_pwm1_compare, out_pwm2_compare, out_led_outputs, out_frame_applied};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected word: pwm1=%h pwm2=%h leds=%b applied=%b",
                     $realtime, got.pwm1, got.pwm2, got.leds, got.applied);
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (got.applied === 1'b1)
            frame_count++;
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"[%0t] mismatch: exp pwm1=%h pwm2=%h leds=%b applied=%b,",
                        " got pwm1=%h pwm2=%h leds=%b applied=%b"},
                       $realtime, want.pwm1, want.pwm2, want.leds, want.applied,
                       got.pwm1, got.pwm2, got.leds, got.applied);
          end
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(predict_parse(in_kind, in_rx_byte));
    end
    pending_count <= pending_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives serial bytes and blink ticks into the command parser: a directed
// run through sync hunting, frame capture and every LED mode, then random
// frames mixed with ticks, noise and broken sync pairs under three
// idle/stall mixes. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sfpwm_pkg::*;

  localparam int CycleLimit = 100000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = KindByte;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_pwm1_compare;
  logic [15:0] out_pwm2_compare;
  logic [2:0]  out_led_outputs;
  logic        out_frame_applied;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int frame_count;
  int send_idle_pct = 28;
  int recv_stall_pct = 67;
  int words_sent = 0;
  int ticks_sent = 0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  sync_framed_pwm_led_command_parser u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pwm1_compare  (out_pwm1_compare),
    .out_pwm2_compare  (out_pwm2_compare),
    .out_led_outputs   (out_led_outputs),
    .out_frame_applied (out_frame_applied)
  );

  sfpwm_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pwm1_compare  (out_pwm1_compare),
    .out_pwm2_compare  (out_pwm2_compare),
    .out_led_outputs   (out_led_outputs),
    .out_frame_applied (out_frame_applied),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count),
    .checked_count     (checked_count),
    .frame_count       (frame_count)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_word(input logic kind, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_rx_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (kind == KindTick)
      ticks_sent++;
  endtask

  task automatic send_byte(input logic [7:0] data);
    send_word(KindByte, data);
  endtask

  task automatic send_tick();
    send_word(KindTick, 8'($urandom_range(255)));
  endtask

  task automatic send_frame(input logic [15:0] duty_one, input logic [15:0] duty_two,
                            input logic [7:0] modes, input int tick_pct);
    logic [7:0] frame_bytes [7];
    frame_bytes = '{SyncFirst, SyncSecond, duty_one[15:8], duty_one[7:0],
                    duty_two[15:8], duty_two[7:0], modes};
    foreach (frame_bytes[i]) begin
      if (i > 0 && $urandom_range(99) < tick_pct)
        send_tick();
      send_byte(frame_bytes[i]);
    end
  endtask

  task automatic run_random(input int count);
    int target;
    int roll;
    target = words_sent + count;
    while (words_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        if ($urandom_range(3) == 0)
          send_byte(8'($urandom_range(255)));
        send_frame(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   8'($urandom_range(255)), 15);
      end else if (roll < 85) begin
        send_tick();
      end else begin
        case ($urandom_range(3))
          0: begin
            send_byte(SyncFirst);
            send_byte(8'($urandom_range(255)));
          end
          1: begin
            send_byte(SyncFirst);
            send_byte(SyncFirst);
          end
          2: send_byte(SyncSecond);
          default: send_byte(8'($urandom_range(255)));
        endcase
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // hunt from reset, all pins on, tick inside a frame, data that looks like sync
    send_tick();
    send_frame(16'hFFFF, 16'h0000, 8'h57, 0);
    send_tick();
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(SyncFirst);
    send_tick();
    send_byte(SyncSecond);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hB8);
    send_tick();
    send_frame(16'hAA12, 16'h3456, 8'h2C, 0);
    send_tick();

    run_random(642);
    send_idle_pct  = 67;
    recv_stall_pct = 28;
    run_random(642);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(642);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d words (%0d ticks) under three idle/stall mixes;", words_sent, ticks_sent);
    $display("checked %0d results, %0d of them completing a frame.", checked_count, frame_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("Mismatches: %0d, outstanding: %0d", mismatch_count, pending_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
